// ===== rtl/clsrng_pkg.sv =====
// Shared constants and control types for the combined LCG shuffle random number source.
// Used by every module under rtl; it depends on nothing else.
package clsrng_pkg;

  localparam int GEN_W  = 31;
  localparam int MULT_W = 16;
  localparam int OFS_W  = 8;
  localparam int FRAC_W = 32;

  // Each modulus is 2^31 minus a small offset, so a product folds back cheaply.
  localparam logic [GEN_W-1:0]  MOD1 = 31'd2147483563;
  localparam logic [OFS_W-1:0]  OFS1 = 8'd85;
  localparam logic [MULT_W-1:0] MUL1 = 16'd40014;
  localparam logic [OFS_W-1:0]  OFS2 = 8'd249;
  localparam logic [MULT_W-1:0] MUL2 = 16'd40692;

  localparam logic [GEN_W-1:0] RANGE_TOP  = 31'd2147483562;
  localparam logic [GEN_W-1:0] SEED_RESET = 31'd1;

  // n * 2^32 / MOD1 = 2n + (170 n) / MOD1, since 2^32 = 2 * MOD1 + 170.
  localparam int               FRAC_T_W     = 39;
  localparam logic [7:0]       FRAC_MUL     = 8'd170;
  localparam logic [FRAC_W-1:0] FRACTION_MAX = 32'd4294966780;
  // Smallest integer whose fraction would exceed FRACTION_MAX.
  localparam logic [GEN_W-1:0] FRAC_CLAMP_N = 31'd2147483306;

  localparam int DEFAULT_TABLE_DEPTH = 32;
  localparam int WARMUP_EXTRA        = 8;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;

  typedef struct packed {
    logic init_seed;  // load both generators from the seed, arm the warm-up count
    logic init_cap;   // capture one warm-up step of the first generator
    logic step_cap;   // capture one step of both generators
    logic diff_en;    // form the new number and refill the table slot
    logic frac_a_en;  // first fraction stage
    logic frac_b_en;  // second fraction stage
    logic out_load;   // load the output register
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;   // the warm-up step being captured is the last one
    logic out_free;   // output register can take a new result this cycle
  } status_t;

endpackage

// ===== rtl/clsrng_mulmod.sv =====
// Modular multiply x * mul mod (2^31 - ofs), pipelined through a product register and a fold register.
// Uses clsrng_pkg widths; instantiated twice by clsrng_datapath.
module clsrng_mulmod (
  input  logic                              clk_i,
  input  logic [clsrng_pkg::GEN_W-1:0]      x_i,
  input  logic [clsrng_pkg::MULT_W-1:0]     mul_i,
  input  logic [clsrng_pkg::OFS_W-1:0]      ofs_i,
  output logic [clsrng_pkg::GEN_W-1:0]      y_o
);

  localparam int GW   = clsrng_pkg::GEN_W;
  localparam int MW   = clsrng_pkg::MULT_W;
  localparam int OW   = clsrng_pkg::OFS_W;
  localparam int PW   = GW + MW;
  localparam int HCW  = MW + OW;

  logic [PW-1:0]  prod_q;
  logic [HCW-1:0] hi_c;
  logic [GW:0]    fold_d, fold_q;
  logic [GW:0]    sum2, modulus;

  // Bits at and above 2^31 are worth ofs each, so fold them down twice.
  assign hi_c   = {{OW{1'b0}}, prod_q[PW-1:GW]} * {{MW{1'b0}}, ofs_i};
  assign fold_d = {{(GW+1-HCW){1'b0}}, hi_c} + {1'b0, prod_q[GW-1:0]};

  assign sum2    = {1'b0, fold_q[GW-1:0]} +
                   (fold_q[GW] ? {{(GW+1-OW){1'b0}}, ofs_i} : '0);
  assign modulus = {1'b1, {GW{1'b0}}} - {{(GW+1-OW){1'b0}}, ofs_i};

  always_ff @(posedge clk_i) begin
    prod_q <= {{MW{1'b0}}, x_i} * {{GW{1'b0}}, mul_i};
    fold_q <= fold_d;
  end

  always_comb begin
    if (sum2 >= modulus) begin
      y_o = GW'(sum2 - modulus);
    end else begin
      y_o = sum2[GW-1:0];
    end
  end

endmodule

// ===== rtl/clsrng_datapath.sv =====
// Datapath: seed register, both generators, shuffle table, slot index, fraction and
// output register. Depends on clsrng_pkg and clsrng_mulmod; driven by clsrng_ctrl.
module clsrng_datapath #(
  parameter int TABLE_DEPTH = clsrng_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [clsrng_pkg::GEN_W-1:0]          cfg_data_i,
  input  clsrng_pkg::cmd_t                      cmd_i,
  output clsrng_pkg::status_t                   status_o,
  output logic                                  m_valid_o,
  input  logic                                  m_ready_i,
  output logic [clsrng_pkg::OUT_TDATA_W-1:0]    m_data_o
);

  localparam int GW     = clsrng_pkg::GEN_W;
  localparam int FW     = clsrng_pkg::FRAC_W;
  localparam int TW     = clsrng_pkg::FRAC_T_W;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WARM   = TABLE_DEPTH + clsrng_pkg::WARMUP_EXTRA;
  localparam int CNT_W  = $clog2(WARM);
  localparam longint unsigned SLOT_DIV =
    64'd1 + 64'(clsrng_pkg::RANGE_TOP) / 64'(TABLE_DEPTH);
  localparam int SLOT_SH = GW + $clog2(SLOT_DIV);
  localparam int RCP_W   = 33;
  localparam int PROD_W  = GW + RCP_W;
  localparam logic [RCP_W-1:0] SLOT_RCP =
    RCP_W'(((64'd1 << SLOT_SH) + SLOT_DIV - 64'd1) / SLOT_DIV);

  logic [GW-1:0]    seed_q, seed_eff;
  logic [GW-1:0]    first_q, second_q, last_q;
  logic [GW-1:0]    y1, y2;
  logic [CNT_W-1:0] cnt_q;
  logic             cnt_zero;

  logic [GW-1:0]    tbl_mem [TABLE_DEPTH];
  logic [GW-1:0]    rd_q;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [GW-1:0]    wr_data;

  logic [PROD_W-1:0] last_ext, rcp_ext, slot_prod_q, slot_quo;
  logic [IDX_W-1:0]  slot_d, slot_q;

  logic [GW:0]      diff, wrap;
  logic [GW-1:0]    number_d;

  logic [TW-1:0]    t_q;
  logic [7:0]       e_q;
  logic [FW-1:0]    rem_q, e_c;
  logic             clamp_q;
  logic [FW-1:0]    frac;

  logic                                 out_valid_q;
  logic [clsrng_pkg::OUT_TDATA_W-1:0]   out_data_q;

  assign seed_eff = (seed_q == '0) ? GW'(1) : seed_q;
  assign cnt_zero = (cnt_q == '0);

  clsrng_mulmod u_gen1 (
    .clk_i (clk_i),
    .x_i   (first_q),
    .mul_i (clsrng_pkg::MUL1),
    .ofs_i (clsrng_pkg::OFS1),
    .y_o   (y1)
  );

  clsrng_mulmod u_gen2 (
    .clk_i (clk_i),
    .x_i   (second_q),
    .mul_i (clsrng_pkg::MUL2),
    .ofs_i (clsrng_pkg::OFS2),
    .y_o   (y2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= clsrng_pkg::SEED_RESET;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_data_i;
      end
      if (cmd_i.init_seed) begin
        cnt_q <= CNT_W'(WARM - 1);
      end else if (cmd_i.init_cap && !cnt_zero) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_seed) begin
      first_q  <= seed_eff;
      second_q <= seed_eff;
    end else if (cmd_i.init_cap) begin
      first_q <= y1;
    end else if (cmd_i.step_cap) begin
      first_q  <= y1;
      second_q <= y2;
    end
    if (cmd_i.init_cap && cnt_zero) begin
      last_q <= y1;
    end else if (cmd_i.diff_en) begin
      last_q <= number_d;
    end
  end

  // Slot index = last / SLOT_DIV by reciprocal multiply; exact for any 31-bit value.
  assign last_ext = {{RCP_W{1'b0}}, last_q};
  assign rcp_ext  = {{GW{1'b0}}, SLOT_RCP};
  assign slot_quo = slot_prod_q >> SLOT_SH;
  assign slot_d   = (slot_quo > PROD_W'(TABLE_DEPTH - 1)) ? IDX_W'(TABLE_DEPTH - 1)
                                                          : slot_quo[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    slot_prod_q <= last_ext * rcp_ext;
    slot_q      <= slot_d;
  end

  // Warm-up fills the table from the top slot down; a normal step refills the chosen slot.
  assign wr_en   = cmd_i.diff_en || (cmd_i.init_cap && (cnt_q < CNT_W'(TABLE_DEPTH)));
  assign wr_addr = cmd_i.diff_en ? slot_q : cnt_q[IDX_W-1:0];
  assign wr_data = cmd_i.diff_en ? first_q : y1;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    rd_q <= tbl_mem[slot_q];
  end

  // New number is the slot value minus the second generator, wrapped into 1..RANGE_TOP.
  assign diff = {1'b0, rd_q} - {1'b0, second_q};
  assign wrap = {1'b0, rd_q} + {1'b0, clsrng_pkg::RANGE_TOP} - {1'b0, second_q};
  assign number_d = (diff[GW] || (diff == '0)) ? wrap[GW-1:0] : diff[GW-1:0];

  assign e_c  = {{(FW-8){1'b0}}, t_q[TW-1:GW]} *
                {{(FW-clsrng_pkg::OFS_W){1'b0}}, clsrng_pkg::OFS1};
  assign frac = {last_q, 1'b0} + {{(FW-8){1'b0}}, e_q} +
                FW'(rem_q >= {1'b0, clsrng_pkg::MOD1});

  always_ff @(posedge clk_i) begin
    if (cmd_i.frac_a_en) begin
      t_q <= {{(TW-GW){1'b0}}, last_q} * {{(TW-8){1'b0}}, clsrng_pkg::FRAC_MUL};
    end
    if (cmd_i.frac_b_en) begin
      e_q     <= t_q[TW-1:GW];
      rem_q   <= {1'b0, t_q[GW-1:0]} + e_c;
      clamp_q <= (last_q >= clsrng_pkg::FRAC_CLAMP_N);
    end
    if (cmd_i.out_load) begin
      out_data_q <= {1'b0, (clamp_q ? clsrng_pkg::FRACTION_MAX : frac), last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.cnt_zero = cnt_zero;
  assign status_o.out_free = !out_valid_q || m_ready_i;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

endmodule

// ===== rtl/clsrng_ctrl.sv =====
// Controller state machine: request intake, re-initialization sequencing and step timing.
// Depends on clsrng_pkg; commands clsrng_datapath.
module clsrng_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_i,
  input  logic                 cfg_we_i,
  input  clsrng_pkg::status_t  status_i,
  output clsrng_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_SEED,
    ST_INIT_RUN,
    ST_STEP_RUN,
    ST_DIFF,
    ST_FRAC_A,
    ST_FRAC_B,
    ST_OUTPUT
  } state_e;

  localparam logic [1:0] PH_CAP = 2'd2;

  state_e     state_q;
  logic [1:0] phase_q;
  logic       armed_q;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Phase paces each step through the generator pipelines; a step is captured at PH_CAP.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
      armed_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        armed_q <= 1'b1;
      end else if (state_q == ST_INIT_SEED) begin
        armed_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && req_i) begin
            if (armed_q) begin
              state_q <= ST_INIT_SEED;
            end else begin
              // The accept cycle already fed the pipelines.
              state_q <= ST_STEP_RUN;
              phase_q <= 2'd1;
            end
          end
        end
        ST_INIT_SEED: begin
          state_q <= ST_INIT_RUN;
          phase_q <= '0;
        end
        ST_INIT_RUN: begin
          if (phase_q == PH_CAP) begin
            phase_q <= '0;
            if (status_i.cnt_zero) begin
              state_q <= ST_STEP_RUN;
            end
          end else begin
            phase_q <= phase_q + 2'd1;
          end
        end
        ST_STEP_RUN: begin
          if (phase_q == PH_CAP) begin
            phase_q <= '0;
            state_q <= ST_DIFF;
          end else begin
            phase_q <= phase_q + 2'd1;
          end
        end
        ST_DIFF:   state_q <= ST_FRAC_A;
        ST_FRAC_A: state_q <= ST_FRAC_B;
        ST_FRAC_B: state_q <= ST_OUTPUT;
        ST_OUTPUT: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          phase_q <= '0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.init_seed = (state_q == ST_INIT_SEED);
    cmd_o.init_cap  = (state_q == ST_INIT_RUN) && (phase_q == PH_CAP);
    cmd_o.step_cap  = (state_q == ST_STEP_RUN) && (phase_q == PH_CAP);
    cmd_o.diff_en   = (state_q == ST_DIFF);
    cmd_o.frac_a_en = (state_q == ST_FRAC_A);
    cmd_o.frac_b_en = (state_q == ST_FRAC_B);
    cmd_o.out_load  = (state_q == ST_OUTPUT) && status_i.out_free;
  end

endmodule

// ===== rtl/combined_lcg_shuffle_rng_top.sv =====
// Top level of the combined LCG random number source with Bays-Durham shuffle.
// Depends on clsrng_pkg, clsrng_ctrl, clsrng_datapath (and clsrng_mulmod below it).
//
//  Channel   Direction  Handshake                   Payload
//  s_axis    in         s_axis_tvalid/tready        tdata[0] request, [7:1] zero
//  m_axis    out        m_axis_tvalid/tready        tdata[30:0] number, [62:31] unit_fraction
//  cfg       in         cfg_valid_i/cfg_ready_o     cfg_data_i seed
//
// A request runs through the generator multiply (product and fold registers), the table
// update, and a three-stage fraction path that ends in the output register.
// The first request after reset or after a seed write also runs the warm-up through the
// first generator pipeline, which fills the shuffle table before the request's own step.
// The output register holds a finished result while a new request is accepted; a stalled
// output only stops the following request at its last stage. A request of 0 is accepted
// and changes nothing.
module combined_lcg_shuffle_rng_top #(
  parameter int TABLE_DEPTH = clsrng_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [clsrng_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [0] request
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [clsrng_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [30:0] number,
                                                               // [62:31] unit_fraction
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [clsrng_pkg::GEN_W-1:0]         cfg_data_i
);

  clsrng_pkg::cmd_t    cmd;
  clsrng_pkg::status_t status;
  logic                cfg_we;

  // The user must write seeds only while the block is idle; not enforced, always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  clsrng_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .req_i      (s_axis_tdata[0]),
    .cfg_we_i   (cfg_we),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  clsrng_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata)
  );

endmodule
